@@ hdl/tpid_pkg.sv @@
// Shared widths, command codes and control structs for the two-axis PID block.
// Used by the controller, the datapath, the divider and the top level.
package tpid_pkg;

  localparam int POS_W    = 26;
  localparam int ERR_W    = 27;
  localparam int DIFF_W   = 28;
  localparam int DT_W     = 16;
  localparam int GAIN_W   = 32;
  localparam int RL_W     = 24;
  localparam int INT_W    = 48;
  localparam int RATE_W   = 48;
  localparam int LIM_W    = 21;
  localparam int MUL_W    = 57;
  localparam int ACC_W    = 60;
  localparam int Q_SHIFT  = 24;
  localparam int XH_W     = INT_W - Q_SHIFT;
  localparam int DIV_NW   = 57;
  localparam int DIV_DW   = 20;
  localparam int DIV_CW   = 6;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 32;
  localparam int FLAG_W   = 2;

  localparam logic [DIV_DW-1:0] US_PER_S = 20'd1000000;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_AZ_KP  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_AZ_KI  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_AZ_KD  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ALT_KP = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ALT_KI = 3'd4;
  localparam logic [CFG_IW-1:0] REG_ALT_KD = 3'd5;
  localparam logic [CFG_IW-1:0] REG_RATE   = 3'd6;

  // limit flags
  localparam logic [FLAG_W-1:0] LIM_NONE  = 2'd0;
  localparam logic [FLAG_W-1:0] LIM_UPPER = 2'd1;
  localparam logic [FLAG_W-1:0] LIM_LOWER = 2'd2;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd2;
  localparam logic [OP_W-1:0] OP_LIM_GO    = 4'd3;
  localparam logic [OP_W-1:0] OP_LIM_TAKE  = 4'd4;
  localparam logic [OP_W-1:0] OP_ERR       = 4'd5;
  localparam logic [OP_W-1:0] OP_RATE_GO   = 4'd6;
  localparam logic [OP_W-1:0] OP_RATE_TAKE = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL_LO    = 4'd8;
  localparam logic [OP_W-1:0] OP_MUL_HI    = 4'd9;
  localparam logic [OP_W-1:0] OP_MUL_SUM   = 4'd10;
  localparam logic [OP_W-1:0] OP_I_TAKE    = 4'd11;
  localparam logic [OP_W-1:0] OP_FIN       = 4'd12;
  localparam logic [OP_W-1:0] OP_OUT       = 4'd13;

  // multiply term select
  localparam logic [1:0] MUL_P = 2'd0;
  localparam logic [1:0] MUL_D = 2'd1;
  localparam logic [1:0] MUL_I = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ax;
    logic [1:0]      msel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/tpid_div.sv @@
// Floor dividers: bit-serial signed dividend by a variable positive divisor, and a
// short reciprocal sequence for division by 10^6. Depends on tpid_pkg.
module tpid_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic signed [tpid_pkg::DIV_NW-1:0] n,
  input  logic [tpid_pkg::DIV_DW-1:0]      d,
  output logic                             done,
  output logic signed [tpid_pkg::DIV_NW-1:0] q
);

  logic                           busy;
  logic                           fix;
  logic [tpid_pkg::DIV_CW-1:0]    cnt;
  logic                           neg;
  logic [tpid_pkg::DIV_NW-1:0]    mag;
  logic [tpid_pkg::DIV_DW-1:0]    rem;
  logic [tpid_pkg::DIV_DW-1:0]    d_r;
  logic [tpid_pkg::DIV_DW:0]      r2;
  logic [tpid_pkg::DIV_DW:0]      r2_sub;
  logic                           fits;

  assign r2     = {rem, mag[tpid_pkg::DIV_NW-1]};
  assign r2_sub = r2 - {1'b0, d_r};
  assign fits   = (r2 >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= n[tpid_pkg::DIV_NW-1];
        mag  <= n[tpid_pkg::DIV_NW-1] ? (~n + 1'b1) : n;
        rem  <= '0;
        d_r  <= d;
      end else if (busy) begin
        if (fits) begin
          rem <= r2_sub[tpid_pkg::DIV_DW-1:0];
          mag <= {mag[tpid_pkg::DIV_NW-2:0], 1'b1};
        end else begin
          rem <= r2[tpid_pkg::DIV_DW-1:0];
          mag <= {mag[tpid_pkg::DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == tpid_pkg::DIV_CW'(tpid_pkg::DIV_NW - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
        // negative dividend: round the truncated quotient down
        q <= neg ? (~mag + 1'b1 - {{(tpid_pkg::DIV_NW-1){1'b0}}, (rem != '0)}) : mag;
      end
    end
  end

endmodule

// floor(n / 10^6): drop 2^6, estimate the quotient by 15625 with a
// 32-bit reciprocal (low by at most 32), then divide the small remainder exactly.
// Negative n uses floor(n/d) = ~floor(~n/d).
module tpid_cdiv (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic signed [tpid_pkg::DIV_NW-1:0] n,
  output logic                               done,
  output logic signed [tpid_pkg::DIV_NW-1:0] q
);

  localparam int M_W   = tpid_pkg::DIV_NW - 7;
  localparam int LO_W  = 32;
  localparam int S_EST = 13;
  localparam int QE_W  = M_W + 1 - S_EST;
  localparam int R_W   = 20;
  localparam int RD_W  = M_W + 2;
  localparam int S_LO  = 33;
  localparam logic [LO_W-1:0] RECIP_HI = 32'd2251799813;  // floor(2^45 / 15625)
  localparam logic [R_W-1:0]  RECIP_LO = 20'd549756;      // ceil(2^33 / 15625)
  localparam logic [13:0]     DIV_ODD  = 14'd15625;

  logic [3:0]                    st;
  logic                          neg;
  logic [M_W-1:0]                m6;
  logic [LO_W-1:0]               t;
  logic [QE_W-1:0]               q0;
  logic [R_W-1:0]                r;
  logic [tpid_pkg::DIV_NW-1:0]   m_c;
  logic [2*LO_W-1:0]             plo_c;
  logic [M_W:0]                  est_c;
  logic [RD_W-1:0]               r_c;
  logic [2*R_W-1:0]              q1_c;
  logic [QE_W-1:0]               qm_c;

  assign m_c   = n[tpid_pkg::DIV_NW-1] ? ~n : n;
  assign plo_c = (2*LO_W)'(m6[LO_W-1:0]) * (2*LO_W)'(RECIP_HI);
  assign est_c = (M_W+1)'(m6[M_W-1:LO_W]) * (M_W+1)'(RECIP_HI) + (M_W+1)'(t);
  assign r_c   = RD_W'(m6) - RD_W'(q0) * RD_W'(DIV_ODD);
  assign q1_c  = (2*R_W)'(r) * (2*R_W)'(RECIP_LO);
  assign qm_c  = q0 + QE_W'(q1_c[2*R_W-1:S_LO]);

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '0;
      done <= 1'b0;
    end else begin
      st   <= {st[2:0], go};
      done <= st[3];
      if (go) begin
        neg <= n[tpid_pkg::DIV_NW-1];
        m6  <= m_c[tpid_pkg::DIV_NW-2:6];
      end
      if (st[0]) begin
        t <= plo_c[2*LO_W-1:LO_W];
      end
      if (st[1]) begin
        q0 <= est_c[M_W:S_EST];
      end
      if (st[2]) begin
        r <= r_c[R_W-1:0];
      end
      if (st[3]) begin
        q <= neg ? ~tpid_pkg::DIV_NW'(qm_c) : tpid_pkg::DIV_NW'(qm_c);
      end
    end
  end

endmodule

@@ hdl/tpid_dp.sv @@
// Datapath: gain registers, per-axis state, shared split multiplier,
// the dividers and the output register. Depends on tpid_pkg, tpid_div and tpid_cdiv.
module tpid_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tpid_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [tpid_pkg::CFG_DW-1:0]        cfg_data,
  input  logic signed [tpid_pkg::POS_W-1:0]  az_position,
  input  logic signed [tpid_pkg::POS_W-1:0]  alt_position,
  input  logic signed [tpid_pkg::POS_W-1:0]  az_target,
  input  logic signed [tpid_pkg::POS_W-1:0]  alt_target,
  input  logic [tpid_pkg::DT_W-1:0]          elapsed_us,
  input  tpid_pkg::dp_cmd_t                  cmd_in,
  output tpid_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tpid_pkg::POS_W-1:0]  az_command,
  output logic signed [tpid_pkg::POS_W-1:0]  alt_command,
  output logic [tpid_pkg::FLAG_W-1:0]        az_limited,
  output logic [tpid_pkg::FLAG_W-1:0]        alt_limited
);

  localparam int EDT_W = tpid_pkg::ERR_W + tpid_pkg::DT_W + 1;
  localparam int PLO_W = tpid_pkg::GAIN_W + tpid_pkg::Q_SHIFT + 1;
  localparam int MLO_W = PLO_W - tpid_pkg::Q_SHIFT;
  localparam int PHI_W = tpid_pkg::GAIN_W + tpid_pkg::XH_W;
  localparam int LN_W  = tpid_pkg::RL_W + tpid_pkg::DT_W;

  logic signed [tpid_pkg::GAIN_W-1:0] kp [2];
  logic signed [tpid_pkg::GAIN_W-1:0] ki [2];
  logic signed [tpid_pkg::GAIN_W-1:0] kd [2];
  logic [tpid_pkg::RL_W-1:0]          rl;

  logic signed [tpid_pkg::POS_W-1:0]  pos_r [2];
  logic signed [tpid_pkg::POS_W-1:0]  tgt_r [2];
  logic [tpid_pkg::DT_W-1:0]          dt_r;

  logic signed [tpid_pkg::ERR_W-1:0]  prev [2];
  logic signed [tpid_pkg::INT_W-1:0]  integ [2];
  logic                               first;

  logic signed [tpid_pkg::ERR_W-1:0]  e_r;
  logic signed [tpid_pkg::RATE_W-1:0] rate_r;
  logic [tpid_pkg::LIM_W-1:0]         lim_r;
  logic signed [MLO_W-1:0]            mlo;
  logic signed [PHI_W-1:0]            mhi;
  logic signed [tpid_pkg::ACC_W-1:0]  acc;
  logic signed [tpid_pkg::POS_W-1:0]  res_cmd [2];
  logic [tpid_pkg::FLAG_W-1:0]        res_flag [2];

  logic                               ax;
  logic signed [tpid_pkg::ERR_W-1:0]  e_c;
  logic signed [tpid_pkg::DT_W:0]     dt_s;
  logic signed [EDT_W-1:0]            edt;
  logic signed [tpid_pkg::INT_W:0]    isum;
  logic signed [tpid_pkg::INT_W-1:0]  isat;
  logic signed [tpid_pkg::DIFF_W-1:0] diff;
  logic signed [tpid_pkg::DIV_DW:0]   us_s;
  logic signed [tpid_pkg::RATE_W-1:0] rate_n;
  logic [LN_W-1:0]                    lim_n;
  logic signed [tpid_pkg::GAIN_W-1:0] g;
  logic signed [tpid_pkg::INT_W-1:0]  x;
  logic signed [tpid_pkg::Q_SHIFT:0]  xl;
  logic signed [tpid_pkg::XH_W-1:0]   xh;
  logic signed [PLO_W-1:0]            plo;
  logic signed [PHI_W-1:0]            phi;
  logic signed [tpid_pkg::MUL_W-1:0]  mres;
  logic                               div_go;
  logic signed [tpid_pkg::DIV_NW-1:0] div_n;
  logic [tpid_pkg::DIV_DW-1:0]        div_d;
  logic                               div_done;
  logic signed [tpid_pkg::DIV_NW-1:0] div_q;
  logic                               cdiv_go;
  logic signed [tpid_pkg::DIV_NW-1:0] cdiv_n;
  logic                               cdiv_done;
  logic signed [tpid_pkg::DIV_NW-1:0] cdiv_q;
  logic signed [tpid_pkg::ACC_W-1:0]  pos_w;
  logic signed [tpid_pkg::ACC_W-1:0]  lim_w;
  logic signed [tpid_pkg::ACC_W-1:0]  delta;
  logic signed [tpid_pkg::ACC_W-1:0]  u;
  logic [tpid_pkg::FLAG_W-1:0]        flag;
  logic signed [tpid_pkg::POS_W-1:0]  u_sat;

  assign ax = cmd_in.ax;

  always_comb begin
    e_c  = tpid_pkg::ERR_W'(tgt_r[ax]) - tpid_pkg::ERR_W'(pos_r[ax]);
    dt_s = {1'b0, dt_r};
    edt  = e_c * dt_s;
    isum = (tpid_pkg::INT_W+1)'(integ[ax]) + (tpid_pkg::INT_W+1)'(edt);
    if (isum[tpid_pkg::INT_W] != isum[tpid_pkg::INT_W-1]) begin
      isat = isum[tpid_pkg::INT_W] ? {1'b1, {(tpid_pkg::INT_W-1){1'b0}}}
                                   : {1'b0, {(tpid_pkg::INT_W-1){1'b1}}};
    end else begin
      isat = isum[tpid_pkg::INT_W-1:0];
    end
    // first sample after reset: previous error seeded with this one
    diff   = first ? '0 : tpid_pkg::DIFF_W'(e_r) - tpid_pkg::DIFF_W'(prev[ax]);
    us_s   = {1'b0, tpid_pkg::US_PER_S};
    rate_n = diff * us_s;
    lim_n  = LN_W'(rl) * LN_W'(dt_r);
  end

  // gain times 48-bit operand, split at bit 24 so each product fits one multiplier
  always_comb begin
    unique case (cmd_in.msel)
      tpid_pkg::MUL_P: begin
        g = kp[ax];
        x = tpid_pkg::INT_W'(e_r);
      end
      tpid_pkg::MUL_D: begin
        g = kd[ax];
        x = rate_r;
      end
      default: begin
        g = ki[ax];
        x = integ[ax];
      end
    endcase
    xl   = {1'b0, x[tpid_pkg::Q_SHIFT-1:0]};
    xh   = x[tpid_pkg::INT_W-1:tpid_pkg::Q_SHIFT];
    plo  = g * xl;
    phi  = g * xh;
    mres = tpid_pkg::MUL_W'(mhi) + tpid_pkg::MUL_W'(mlo);
  end

  // derivative divides by dt; rate limit and integral term divide by 10^6
  always_comb begin
    div_go  = (cmd_in.op == tpid_pkg::OP_RATE_GO);
    div_n   = tpid_pkg::DIV_NW'(rate_n);
    div_d   = tpid_pkg::DIV_DW'(dt_r);
    cdiv_go = (cmd_in.op == tpid_pkg::OP_LIM_GO) ||
              (cmd_in.op == tpid_pkg::OP_MUL_SUM && cmd_in.msel == tpid_pkg::MUL_I);
    if (cmd_in.op == tpid_pkg::OP_LIM_GO) begin
      cdiv_n = tpid_pkg::DIV_NW'(lim_n);
    end else begin
      cdiv_n = tpid_pkg::DIV_NW'(mres);
    end
  end

  tpid_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .n    (div_n),
    .d    (div_d),
    .done (div_done),
    .q    (div_q)
  );

  tpid_cdiv u_cdiv (
    .clk  (clk),
    .rst  (rst),
    .go   (cdiv_go),
    .n    (cdiv_n),
    .done (cdiv_done),
    .q    (cdiv_q)
  );

  // rate limit around the measured position, then saturate
  always_comb begin
    pos_w = tpid_pkg::ACC_W'(pos_r[ax]);
    lim_w = tpid_pkg::ACC_W'({1'b0, lim_r});
    delta = acc - pos_w;
    if (delta > lim_w) begin
      u    = pos_w + lim_w;
      flag = tpid_pkg::LIM_UPPER;
    end else if (delta < -lim_w) begin
      u    = pos_w - lim_w;
      flag = tpid_pkg::LIM_LOWER;
    end else begin
      u    = acc;
      flag = tpid_pkg::LIM_NONE;
    end
    if (u > (tpid_pkg::ACC_W'(1) <<< (tpid_pkg::POS_W-1)) - 1) begin
      u_sat = {1'b0, {(tpid_pkg::POS_W-1){1'b1}}};
    end else if (u < -(tpid_pkg::ACC_W'(1) <<< (tpid_pkg::POS_W-1))) begin
      u_sat = {1'b1, {(tpid_pkg::POS_W-1){1'b0}}};
    end else begin
      u_sat = u[tpid_pkg::POS_W-1:0];
    end
  end

  assign stat.div_done = div_done | cdiv_done;
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp[0] <= 32'sd1677722;
      ki[0] <= 32'sd167772;
      kd[0] <= 32'sd16777216;
      kp[1] <= 32'sd16777216;
      ki[1] <= 32'sd3355443;
      kd[1] <= 32'sd0;
      rl    <= 24'd14877;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tpid_pkg::REG_AZ_KP:  kp[0] <= cfg_data;
        tpid_pkg::REG_AZ_KI:  ki[0] <= cfg_data;
        tpid_pkg::REG_AZ_KD:  kd[0] <= cfg_data;
        tpid_pkg::REG_ALT_KP: kp[1] <= cfg_data;
        tpid_pkg::REG_ALT_KI: ki[1] <= cfg_data;
        tpid_pkg::REG_ALT_KD: kd[1] <= cfg_data;
        tpid_pkg::REG_RATE:   rl    <= cfg_data[tpid_pkg::RL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev[0]   <= '0;
      prev[1]   <= '0;
      integ[0]  <= '0;
      integ[1]  <= '0;
      first     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd_in.op == tpid_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (cmd_in.op)
        tpid_pkg::OP_LOAD: begin
          pos_r[0] <= az_position;
          pos_r[1] <= alt_position;
          tgt_r[0] <= az_target;
          tgt_r[1] <= alt_target;
          dt_r     <= (elapsed_us == '0) ? tpid_pkg::DT_W'(1) : elapsed_us;
        end
        tpid_pkg::OP_CLEAR: begin
          prev[0]  <= '0;
          prev[1]  <= '0;
          integ[0] <= '0;
          integ[1] <= '0;
        end
        tpid_pkg::OP_LIM_TAKE: lim_r <= cdiv_q[tpid_pkg::LIM_W-1:0];
        tpid_pkg::OP_ERR: begin
          e_r       <= e_c;
          integ[ax] <= isat;
        end
        tpid_pkg::OP_RATE_GO:   prev[ax] <= e_r;
        tpid_pkg::OP_RATE_TAKE: rate_r <= div_q[tpid_pkg::RATE_W-1:0];
        tpid_pkg::OP_MUL_LO:    mlo <= MLO_W'(plo >>> tpid_pkg::Q_SHIFT);
        tpid_pkg::OP_MUL_HI:    mhi <= phi;
        tpid_pkg::OP_MUL_SUM: begin
          if (cmd_in.msel == tpid_pkg::MUL_P) begin
            acc <= tpid_pkg::ACC_W'(mres);
          end else if (cmd_in.msel == tpid_pkg::MUL_D) begin
            acc <= acc + tpid_pkg::ACC_W'(mres);
          end
        end
        tpid_pkg::OP_I_TAKE: acc <= acc + tpid_pkg::ACC_W'(cdiv_q);
        tpid_pkg::OP_FIN: begin
          res_cmd[ax]  <= u_sat;
          res_flag[ax] <= flag;
          if (ax) begin
            first <= 1'b0;
          end
        end
        tpid_pkg::OP_OUT: begin
          az_command  <= res_cmd[0];
          alt_command <= res_cmd[1];
          az_limited  <= res_flag[0];
          alt_limited <= res_flag[1];
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/tpid_ctrl.sv @@
// Controller: sequences limit, per-axis error, derivative divide, the three
// gain multiplies, the integral divide and the output transfer, or a clear. Depends on tpid_pkg.
module tpid_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_stall,
  input  tpid_pkg::dp_stat_t stat,
  output tpid_pkg::dp_cmd_t  cmd_out
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LSTART = 4'd1;
  localparam logic [3:0] S_LWAIT  = 4'd2;
  localparam logic [3:0] S_ERR    = 4'd3;
  localparam logic [3:0] S_RSTART = 4'd4;
  localparam logic [3:0] S_RWAIT  = 4'd5;
  localparam logic [3:0] S_ML     = 4'd6;
  localparam logic [3:0] S_MH     = 4'd7;
  localparam logic [3:0] S_MS     = 4'd8;
  localparam logic [3:0] S_IWAIT  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state, state_next;
  logic       ax, ax_next;
  logic [1:0] msel, msel_next;
  logic [tpid_pkg::OP_W-1:0] op;

  assign in_stall     = (state != S_IDLE);
  assign cmd_out.op   = op;
  assign cmd_out.ax   = ax;
  assign cmd_out.msel = msel;

  always_comb begin
    state_next = state;
    ax_next    = ax;
    msel_next  = msel;
    op         = tpid_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd) begin
            op = tpid_pkg::OP_CLEAR;
          end else begin
            op         = tpid_pkg::OP_LOAD;
            state_next = S_LSTART;
          end
        end
      end
      S_LSTART: begin
        op         = tpid_pkg::OP_LIM_GO;
        state_next = S_LWAIT;
      end
      S_LWAIT: begin
        if (stat.div_done) begin
          op         = tpid_pkg::OP_LIM_TAKE;
          ax_next    = 1'b0;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        op         = tpid_pkg::OP_ERR;
        state_next = S_RSTART;
      end
      S_RSTART: begin
        op         = tpid_pkg::OP_RATE_GO;
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        if (stat.div_done) begin
          op         = tpid_pkg::OP_RATE_TAKE;
          msel_next  = tpid_pkg::MUL_P;
          state_next = S_ML;
        end
      end
      S_ML: begin
        op         = tpid_pkg::OP_MUL_LO;
        state_next = S_MH;
      end
      S_MH: begin
        op         = tpid_pkg::OP_MUL_HI;
        state_next = S_MS;
      end
      S_MS: begin
        op = tpid_pkg::OP_MUL_SUM;
        priority if (msel == tpid_pkg::MUL_P) begin
          msel_next  = tpid_pkg::MUL_D;
          state_next = S_ML;
        end else if (msel == tpid_pkg::MUL_D) begin
          msel_next  = tpid_pkg::MUL_I;
          state_next = S_ML;
        end else begin
          state_next = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (stat.div_done) begin
          op         = tpid_pkg::OP_I_TAKE;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        op = tpid_pkg::OP_FIN;
        if (!ax) begin
          ax_next    = 1'b1;
          state_next = S_ERR;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          op         = tpid_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax    <= 1'b0;
      msel  <= tpid_pkg::MUL_P;
    end else begin
      state <= state_next;
      ax    <= ax_next;
      msel  <= msel_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_LWAIT || state == S_RWAIT || state == S_IWAIT))
    else $error("divider finished outside a wait state");
  a_out_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && stat.out_free) |=> state == S_IDLE)
    else $error("result transfer did not return to idle");
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && !in_cmd) |=> state == S_LSTART)
    else $error("control sample not started");
  a_second_axis: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !ax) |=> (state == S_ERR && ax))
    else $error("altitude axis not sequenced after azimuth");
`endif

endmodule

@@ hdl/two_axis_pid_rate_limited.sv @@
// Top level of the two-axis rate-limited PID controller.
// Depends on tpid_pkg, tpid_ctrl, tpid_dp (which holds tpid_div and tpid_cdiv).
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  cmd, positions, targets, elapsed_us
//  out      source     out_valid/out_stall  az/alt_command, az/alt_limited
//  cfg      sink       cfg_write            cfg_index, cfg_data
//
// A control sample holds in_stall high after its transfer until its result enters the
// output register, so no new sample is taken before the last one is done. The two
// bit-serial derivative divides by dt take most of that span; the limit and integral
// divides by 10^6 use a reciprocal sequence, and each axis runs three split multiplies
// of three steps. A clear gives no result and does not raise in_stall.
// Reset is synchronous; gains return to their defaults. A stalled result keeps the
// block in its output step, so in_stall stays high until the output register frees.
module two_axis_pid_rate_limited (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tpid_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [tpid_pkg::CFG_DW-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic signed [tpid_pkg::POS_W-1:0]  az_position,
  input  logic signed [tpid_pkg::POS_W-1:0]  alt_position,
  input  logic signed [tpid_pkg::POS_W-1:0]  az_target,
  input  logic signed [tpid_pkg::POS_W-1:0]  alt_target,
  input  logic [tpid_pkg::DT_W-1:0]          elapsed_us,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tpid_pkg::POS_W-1:0]  az_command,
  output logic signed [tpid_pkg::POS_W-1:0]  alt_command,
  output logic [tpid_pkg::FLAG_W-1:0]        az_limited,
  output logic [tpid_pkg::FLAG_W-1:0]        alt_limited
);

  tpid_pkg::dp_cmd_t  dp_cmd;
  tpid_pkg::dp_stat_t dp_stat;

  tpid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd_out  (dp_cmd)
  );

  tpid_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .az_position  (az_position),
    .alt_position (alt_position),
    .az_target    (az_target),
    .alt_target   (alt_target),
    .elapsed_us   (elapsed_us),
    .cmd_in       (dp_cmd),
    .stat         (dp_stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .az_command   (az_command),
    .alt_command  (alt_command),
    .az_limited   (az_limited),
    .alt_limited  (alt_limited)
  );

endmodule
